@@ src/srs_pkg.sv @@
// ----------------------------------------------------------------------------
// Selective-repeat sender package
// Shared item codes, result codes and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package srs_pkg;

  // Kind of input item
  typedef enum logic [1:0] {
    MODE_SEND    = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_TIMEOUT = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_SENT        = 3'd0,
    ST_REFUSED     = 3'd1,
    ST_ACK_TAKEN   = 3'd2,
    ST_BAD_CSUM    = 3'd3,
    ST_REDUNDANT   = 3'd4,
    ST_RETRANSMIT  = 3'd5,
    ST_TIMEOUT_IGN = 3'd6
  } status_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;  // latch the accepted item
    logic exec;       // decode and update the window
    logic read_done;  // pick up retransmit payload from memory
    logic slide;      // release one acked entry at the head
    logic load_out;   // move the result into the output register
  } srs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic item_nop;        // unused item kind, no result
    logic item_timeout;    // timer expiry item
    logic item_ack_taken;  // ack that goes on to the slide
    logic slide_more;      // head entry is acked and window not empty
    logic out_free;        // output register can take a result
  } srs_stat_t;

endpackage

@@ src/srs_ctrl.sv @@
// ----------------------------------------------------------------------------
// Selective-repeat sender controller
// One-hot sequencer stepping each item through decode and, as its kind needs, read, slide and output.
// ----------------------------------------------------------------------------
module srs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  srs_pkg::srs_stat_t stat,
  output srs_pkg::srs_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_READ  = 5'b00100,
    S_SLIDE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (stat.item_nop) state_next = S_IDLE;
        else if (stat.item_timeout) state_next = S_READ;
        else if (stat.item_ack_taken) state_next = S_SLIDE;
        else state_next = S_DONE;
      end
      S_READ: begin
        state_next = S_DONE;
      end
      S_SLIDE: begin
        if (!stat.slide_more) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Commands
  assign in_ready      = (state == S_IDLE);
  assign cmd.load_item = (state == S_IDLE) && in_valid;
  assign cmd.exec      = (state == S_EXEC) && !stat.item_nop;
  assign cmd.read_done = (state == S_READ);
  assign cmd.slide     = (state == S_SLIDE) && stat.slide_more;
  assign cmd.load_out  = (state == S_DONE) && stat.out_free;

endmodule

@@ src/srs_dp.sv @@
// ----------------------------------------------------------------------------
// Selective-repeat sender datapath
// Window registers, payload memory, acked flags, result and output registers.
// ----------------------------------------------------------------------------
module srs_dp #(
  parameter int WINDOW_MAX   = 8,
  parameter int PAYLOAD_BITS = 32,
  parameter int SEQ_BITS     = 16,
  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
  localparam int OW = $clog2(WINDOW_MAX + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  srs_pkg::srs_cmd_t       cmd,
  output srs_pkg::srs_stat_t      stat,
  // item fields
  input  srs_pkg::mode_t          in_mode,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  input  logic [SEQ_BITS-1:0]     in_ack_number,
  input  logic                    in_checksum_ok,
  input  logic [SEQ_BITS-1:0]     in_expired_seq,
  // register write/read
  input  logic                    cfg_we,
  input  logic [3:0]              cfg_wdata,
  output logic [3:0]              window_size,
  // result
  output logic                    out_valid,
  input  logic                    out_ready,
  output srs_pkg::status_t        out_status,
  output logic [SEQ_BITS-1:0]     out_packet_seq,
  output logic [PAYLOAD_BITS-1:0] out_packet_payload,
  output logic                    out_start_timer,
  output logic                    out_stop_timer,
  output logic                    out_window_full,
  output logic [OW-1:0]           out_released_count
);

  localparam int DW = (SEQ_BITS > OW) ? SEQ_BITS : OW;
  localparam int CW = (OW > 4) ? OW : 4;

  // Circular slot arithmetic: base + off, both below the window depth
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [IW-1:0] off);
    logic [IW:0] sum;
    begin
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (IW+1)'(WINDOW_MAX)) sum = sum - (IW+1)'(WINDOW_MAX);
      return sum[IW-1:0];
    end
  endfunction

  // Window state
  logic [IW-1:0]           head;
  logic [OW-1:0]           occ;
  logic [SEQ_BITS-1:0]     last_seq;
  logic                    acked [WINDOW_MAX];
  logic [PAYLOAD_BITS-1:0] mem [WINDOW_MAX];
  logic [PAYLOAD_BITS-1:0] mem_q;

  // Latched item
  srs_pkg::mode_t          item_mode;
  logic [PAYLOAD_BITS-1:0] item_pay;
  logic [SEQ_BITS-1:0]     item_ackn;
  logic                    item_csok;
  logic [SEQ_BITS-1:0]     item_exps;

  // Result under construction
  srs_pkg::status_t        r_status;
  logic [SEQ_BITS-1:0]     r_seq;
  logic [PAYLOAD_BITS-1:0] r_pay;
  logic                    r_st;
  logic                    r_sp;
  logic [OW-1:0]           r_rel;

  // Decode
  logic [SEQ_BITS-1:0] head_seq;
  logic [SEQ_BITS-1:0] ack_d;
  logic [SEQ_BITS-1:0] exp_d;
  logic                ack_in;
  logic                exp_in;
  logic                ack_take;
  logic                exp_hit;
  logic [IW-1:0]       send_slot;
  logic [IW-1:0]       ack_slot;
  logic [IW-1:0]       exp_slot;
  logic [CW-1:0]       eff_win;
  logic                full;
  logic                send_ok;

  // Sequence numbers in the window run on from the head's
  assign head_seq  = last_seq - SEQ_BITS'(occ) + SEQ_BITS'(1);
  assign ack_d     = item_ackn - head_seq;
  assign exp_d     = item_exps - head_seq;
  assign ack_in    = DW'(ack_d) < DW'(occ);
  assign exp_in    = DW'(exp_d) < DW'(occ);
  assign send_slot = slot_of(head, IW'(occ));
  assign ack_slot  = slot_of(head, IW'(ack_d));
  assign exp_slot  = slot_of(head, IW'(exp_d));
  assign exp_hit   = exp_in && !acked[exp_slot];
  assign ack_take  = item_csok && (occ != '0) && !ack_d[SEQ_BITS-1];

  assign eff_win = (CW'(window_size) > CW'(WINDOW_MAX)) ? CW'(WINDOW_MAX)
                                                        : CW'(window_size);
  assign full    = CW'(occ) >= eff_win;
  assign send_ok = !full;

  // Status to controller
  assign stat.item_nop       = (item_mode == srs_pkg::MODE_NONE);
  assign stat.item_timeout   = (item_mode == srs_pkg::MODE_TIMEOUT);
  assign stat.item_ack_taken = (item_mode == srs_pkg::MODE_ACK) && ack_take;
  assign stat.slide_more     = (occ != '0) && acked[head];
  assign stat.out_free       = !out_valid || out_ready;

  // Window size register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= 4'd4;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  // Item latch
  always_ff @(posedge clk) begin
    if (rst) begin
      item_mode <= srs_pkg::MODE_NONE;
    end else if (cmd.load_item) begin
      item_mode <= in_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_pay  <= in_payload;
      item_ackn <= in_ack_number;
      item_csok <= in_checksum_ok;
      item_exps <= in_expired_seq;
    end
  end

  // Head, occupancy and sequence counter
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      occ      <= '0;
      last_seq <= '0;
    end else if (cmd.exec && item_mode == srs_pkg::MODE_SEND && send_ok) begin
      occ      <= occ + OW'(1);
      last_seq <= last_seq + SEQ_BITS'(1);
    end else if (cmd.slide) begin
      head <= slot_of(head, IW'(1));
      occ  <= occ - OW'(1);
    end
  end

  // Acked flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_MAX; i++) acked[i] <= 1'b0;
    end else if (cmd.exec) begin
      if (item_mode == srs_pkg::MODE_SEND && send_ok) acked[send_slot] <= 1'b0;
      if (item_mode == srs_pkg::MODE_ACK && ack_take && ack_in) acked[ack_slot] <= 1'b1;
    end else if (cmd.slide) begin
      acked[head] <= 1'b0;
    end
  end

  // Payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && item_mode == srs_pkg::MODE_SEND && send_ok) begin
      mem[send_slot] <= item_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      mem_q <= mem[exp_slot];
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      r_pay <= '0;
      r_st  <= 1'b0;
      r_sp  <= 1'b0;
      r_rel <= '0;
      r_seq <= '0;
      case (item_mode)
        srs_pkg::MODE_SEND: begin
          if (send_ok) begin
            r_status <= srs_pkg::ST_SENT;
            r_seq    <= last_seq + SEQ_BITS'(1);
            r_pay    <= item_pay;
            r_st     <= 1'b1;
          end else begin
            r_status <= srs_pkg::ST_REFUSED;
          end
        end
        srs_pkg::MODE_ACK: begin
          r_seq <= item_ackn;
          if (!item_csok) r_status <= srs_pkg::ST_BAD_CSUM;
          else if (!ack_take) r_status <= srs_pkg::ST_REDUNDANT;
          else begin
            r_status <= srs_pkg::ST_ACK_TAKEN;
            r_sp     <= ack_in;
          end
        end
        default: begin
          r_seq    <= item_exps;
          r_st     <= exp_hit;
          r_status <= exp_hit ? srs_pkg::ST_RETRANSMIT : srs_pkg::ST_TIMEOUT_IGN;
        end
      endcase
    end else if (cmd.read_done) begin
      if (r_st) r_pay <= mem_q;
    end else if (cmd.slide) begin
      r_rel <= r_rel + OW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status         <= r_status;
      out_packet_seq     <= r_seq;
      out_packet_payload <= r_pay;
      out_start_timer    <= r_st;
      out_stop_timer     <= r_sp;
      out_window_full    <= full;
      out_released_count <= r_rel;
    end
  end

endmodule

@@ src/selective_repeat_sender_core.sv @@
// ----------------------------------------------------------------------------
// Selective-repeat ARQ sender core
// Send window with sequence numbering, ack sliding and timeout retransmit.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per handshake: a send, an ack or a timer expiry,
//   selected by tuser. m_axis returns one result item per input item (the
//   unused fourth kind gives none). The APB port holds window_size at
//   address 0; write it only while the core is idle.
//   Items are handled one at a time by the sequencer. From acceptance the
//   result reaches the output register after the decode step for a send, a
//   refused send or a dropped ack, after decode and a payload memory read
//   for a timer expiry, and after decode and the slide for a taken ack that
//   releases entries (one entry per cycle off the head). The next item is
//   taken once the result has moved into the output register; an item of
//   the unused kind returns to idle straight after decode.
//   A stalled receiver holds the result in the output register; the core
//   still takes the next item and parks its result until the register frees.
//   Reset empties the window, restarts numbering at 1, sets window_size to 4
//   and drops any pending result.
// ----------------------------------------------------------------------------
module selective_repeat_sender_core #(
  parameter int WINDOW_MAX   = 8,
  parameter int PAYLOAD_BITS = 32,
  parameter int SEQ_BITS     = 16,
  localparam int OW  = $clog2(WINDOW_MAX + 1),
  localparam int IFW = PAYLOAD_BITS + 2 * SEQ_BITS,
  localparam int IDW = ((IFW + 7) / 8) * 8,
  localparam int OFW = SEQ_BITS + PAYLOAD_BITS + 3 + OW,
  localparam int ODW = ((OFW + 7) / 8) * 8
) (
  input  logic           clk,
  input  logic           rst,
  // input items
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [IDW-1:0] s_axis_tdata,   // payload, ack_number, expired_seq
  input  logic [2:0]     s_axis_tuser,   // mode[1:0], checksum_ok
  // result items
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [ODW-1:0] m_axis_tdata,   // packet_seq, packet_payload,
                                         // start_timer, stop_timer,
                                         // window_full, released_count
  output logic [2:0]     m_axis_tuser,   // status
  // configuration
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [1:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  srs_pkg::srs_cmd_t       cmd;
  srs_pkg::srs_stat_t      stat;
  srs_pkg::status_t        o_status;
  logic [SEQ_BITS-1:0]     o_seq;
  logic [PAYLOAD_BITS-1:0] o_pay;
  logic                    o_st;
  logic                    o_sp;
  logic                    o_full;
  logic [OW-1:0]           o_rel;
  logic [3:0]              window_size;
  logic                    cfg_we;
  logic [OFW-1:0]          o_fields;

  // APB register access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr == 2'd0);
  assign prdata = (paddr == 2'd0) ? {28'd0, window_size} : 32'd0;

  srs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srs_dp #(
    .WINDOW_MAX   (WINDOW_MAX),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .SEQ_BITS     (SEQ_BITS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .in_mode            (srs_pkg::mode_t'(s_axis_tuser[1:0])),
    .in_payload         (s_axis_tdata[PAYLOAD_BITS-1:0]),
    .in_ack_number      (s_axis_tdata[PAYLOAD_BITS +: SEQ_BITS]),
    .in_checksum_ok     (s_axis_tuser[2]),
    .in_expired_seq     (s_axis_tdata[PAYLOAD_BITS + SEQ_BITS +: SEQ_BITS]),
    .cfg_we             (cfg_we),
    .cfg_wdata          (pwdata[3:0]),
    .window_size        (window_size),
    .out_valid          (m_axis_tvalid),
    .out_ready          (m_axis_tready),
    .out_status         (o_status),
    .out_packet_seq     (o_seq),
    .out_packet_payload (o_pay),
    .out_start_timer    (o_st),
    .out_stop_timer     (o_sp),
    .out_window_full    (o_full),
    .out_released_count (o_rel)
  );

  // Result packing, first field lowest
  assign o_fields     = {o_rel, o_full, o_sp, o_st, o_pay, o_seq};
  assign m_axis_tdata = ODW'(o_fields);
  assign m_axis_tuser = o_status;

endmodule

@@ src/srs_checker.sv @@
// ----------------------------------------------------------------------------
// Selective-repeat sender port checker
// Watches the result channel of the core and is bound to its top level.
// ----------------------------------------------------------------------------
module srs_checker #(
  parameter int WINDOW_MAX   = 8,
  parameter int PAYLOAD_BITS = 32,
  parameter int SEQ_BITS     = 16,
  localparam int OW  = $clog2(WINDOW_MAX + 1),
  localparam int OFW = SEQ_BITS + PAYLOAD_BITS + 3 + OW,
  localparam int ODW = ((OFW + 7) / 8) * 8
) (
  input logic           clk,
  input logic           rst,
  input logic           m_axis_tvalid,
  input logic           m_axis_tready,
  input logic [ODW-1:0] m_axis_tdata,
  input logic [2:0]     m_axis_tuser
);

  localparam int ST_BIT   = SEQ_BITS + PAYLOAD_BITS;
  localparam int SP_BIT   = ST_BIT + 1;
  localparam int FULL_BIT = ST_BIT + 2;
  localparam int REL_LSB  = ST_BIT + 3;

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed under stall");

  // Fresh send starts its timer and releases nothing
  a_sent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == srs_pkg::ST_SENT |->
      m_axis_tdata[ST_BIT] && !m_axis_tdata[SP_BIT] &&
      m_axis_tdata[REL_LSB +: OW] == '0)
    else $error("send result malformed");

  // Refused send leaves the window full and emits no packet
  a_refused: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == srs_pkg::ST_REFUSED |->
      m_axis_tdata[FULL_BIT] && !m_axis_tdata[ST_BIT] &&
      m_axis_tdata[SEQ_BITS-1:0] == '0)
    else $error("refused send malformed");

  // No result straight out of reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind selective_repeat_sender_core srs_checker #(
  .WINDOW_MAX   (WINDOW_MAX),
  .PAYLOAD_BITS (PAYLOAD_BITS),
  .SEQ_BITS     (SEQ_BITS)
) u_srs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Selective-repeat sender core testbench
// Drives send, ack and timer-expiry items into the core over the input stream
// and checks every result item against an in-bench model of the send window.
// The model is kept in step with the accepted items and the window_size
// writes. The stimulus covers a directed opening, random traffic under
// several window sizes and idling mixes, and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] WINDOW_SIZE_ADDR = 2'd0;
  localparam int         WIN_DEPTH        = 8;
  localparam int         DRAIN_CYCLES     = 24;
  localparam int         STALL_LIMIT      = 5000;
  localparam int         LONG_HOLD        = 400;
  localparam int         MAX_REPORTS      = 10;

  // One input item, unpacked
  typedef struct packed {
    srs_pkg::mode_t mode;
    logic           csum_ok;
    logic [15:0]    exp_seq;
    logic [15:0]    ack_no;
    logic [31:0]    payload;
  } arq_item_t;

  // One result item, unpacked
  typedef struct packed {
    srs_pkg::status_t status;
    logic [15:0]      seq;
    logic [31:0]      payload;
    logic             start_tmr;
    logic             stop_tmr;
    logic             full;
    logic [3:0]       released;
  } arq_result_t;

  // Send window contents
  typedef struct packed {
    logic [WIN_DEPTH-1:0][15:0] seq;
    logic [WIN_DEPTH-1:0]       acked;
    logic [WIN_DEPTH-1:0][31:0] data;
    logic [2:0]                 head;
    logic [3:0]                 occ;
    logic [15:0]                last;
    logic [3:0]                 wsize;
  } send_window_t;

  // Window after one item, plus the result it gives
  typedef struct packed {
    send_window_t win;
    arq_result_t  res;
    logic         has_res;
  } window_update_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;    // payload, ack_number, expired_seq
  logic [2:0]  s_axis_tuser = '0;    // mode[1:0], checksum_ok
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;         // packet_seq, packet_payload, start_timer,
                                     // stop_timer, window_full, released_count
  logic [2:0]  m_axis_tuser;         // status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  selective_repeat_sender_core DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk = ~clk;

  arq_item_t      item_queue[$];
  arq_result_t    due_results[$];
  send_window_t   sender_state;   // follows accepted items, for checking
  send_window_t   plan_state;     // follows queued items, for stimulus choice
  window_update_t upd;
  arq_item_t      drive_item;
  arq_item_t      seen_item;
  arq_result_t    got_res;
  arq_result_t    want_res;
  logic           s_fire = 1'b0;
  logic           m_fire = 1'b0;
  int             err_count = 0;
  int             quiet_cycles = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             hold_left = 0;
  logic           long_hold_req = 1'b0;
  logic           hold_done = 1'b0;

  function automatic send_window_t window_at_reset();
    send_window_t w;
    w = '0;
    w.wsize = 4'd4;
    return w;
  endfunction

  // Window behaviour for one item
  function automatic window_update_t window_step(send_window_t w, arq_item_t it);
    window_update_t u;
    logic [3:0]  eff;
    logic [2:0]  sl;
    logic [15:0] age;
    logic        found;
    int          idx;
    u = '0;
    u.has_res = 1'b1;
    found = 1'b0;
    eff = (w.wsize > WIN_DEPTH) ? 4'(WIN_DEPTH) : w.wsize;
    case (it.mode)
      srs_pkg::MODE_SEND: begin
        if (w.occ >= eff) begin
          u.res.status = srs_pkg::ST_REFUSED;
        end else begin
          sl = w.head + w.occ[2:0];
          w.last = w.last + 16'd1;
          w.seq[sl] = w.last;
          w.data[sl] = it.payload;
          w.acked[sl] = 1'b0;
          w.occ = w.occ + 4'd1;
          u.res.status = srs_pkg::ST_SENT;
          u.res.seq = w.last;
          u.res.payload = it.payload;
          u.res.start_tmr = 1'b1;
        end
      end
      srs_pkg::MODE_ACK: begin
        u.res.seq = it.ack_no;
        age = it.ack_no - w.seq[w.head];
        if (!it.csum_ok) begin
          u.res.status = srs_pkg::ST_BAD_CSUM;
        end else if (w.occ == 0 || age[15]) begin
          // empty window, or older than the head
          u.res.status = srs_pkg::ST_REDUNDANT;
        end else begin
          u.res.status = srs_pkg::ST_ACK_TAKEN;
          for (idx = 0; idx < WIN_DEPTH; idx++) begin
            sl = w.head + idx[2:0];
            if (!found && idx < w.occ && w.seq[sl] == it.ack_no) begin
              w.acked[sl] = 1'b1;
              u.res.stop_tmr = 1'b1;
              found = 1'b1;
            end
          end
          // slide acked entries off the head
          for (idx = 0; idx < WIN_DEPTH; idx++) begin
            if (w.occ != 0 && w.acked[w.head]) begin
              w.acked[w.head] = 1'b0;
              w.head = w.head + 3'd1;
              w.occ = w.occ - 4'd1;
              u.res.released = u.res.released + 4'd1;
            end
          end
        end
      end
      srs_pkg::MODE_TIMEOUT: begin
        u.res.status = srs_pkg::ST_TIMEOUT_IGN;
        u.res.seq = it.exp_seq;
        for (idx = 0; idx < WIN_DEPTH; idx++) begin
          sl = w.head + idx[2:0];
          if (!found && idx < w.occ && w.seq[sl] == it.exp_seq && !w.acked[sl]) begin
            u.res.status = srs_pkg::ST_RETRANSMIT;
            u.res.payload = w.data[sl];
            u.res.start_tmr = 1'b1;
            found = 1'b1;
          end
        end
      end
      default: u.has_res = 1'b0;
    endcase
    u.res.full = (w.occ >= eff);
    u.win = w;
    return u;
  endfunction

  function automatic arq_item_t mk_item(srs_pkg::mode_t m, logic [31:0] pay,
                                       logic [15:0] ackn, logic csok,
                                       logic [15:0] exps);
    arq_item_t it;
    it.mode = m;
    it.payload = pay;
    it.ack_no = ackn;
    it.csum_ok = csok;
    it.exp_seq = exps;
    return it;
  endfunction

  // Mostly well-formed traffic against the planned window, some noise
  function automatic arq_item_t pick_item();
    arq_item_t   it;
    logic [3:0]  eff;
    logic [2:0]  sl;
    int          roll;
    it = mk_item(srs_pkg::MODE_SEND, $urandom, 16'($urandom), 1'b1, 16'($urandom));
    eff = (plan_state.wsize > WIN_DEPTH) ? 4'(WIN_DEPTH) : plan_state.wsize;
    sl = plan_state.head;
    if (plan_state.occ != 0)
      sl = plan_state.head + 3'($urandom_range(0, plan_state.occ - 1));
    roll = $urandom_range(0, 99);
    if (roll < 45 && plan_state.occ < eff) begin
      it.mode = srs_pkg::MODE_SEND;
    end else if (roll < 80 && plan_state.occ != 0) begin
      it.mode = srs_pkg::MODE_ACK;
      it.ack_no = plan_state.seq[sl];
    end else if (roll < 88 && plan_state.occ != 0) begin
      it.mode = srs_pkg::MODE_TIMEOUT;
      it.exp_seq = plan_state.seq[sl];
    end else begin
      case ($urandom_range(0, 5))
        0: begin
          it.mode = srs_pkg::MODE_ACK;
          it.csum_ok = 1'b0;
          if ($urandom_range(0, 1)) it.ack_no = plan_state.seq[sl];
        end
        1: it.mode = srs_pkg::MODE_ACK;
        2: begin
          it.mode = srs_pkg::MODE_ACK;
          it.ack_no = plan_state.seq[plan_state.head] - 16'($urandom_range(1, 32768));
        end
        3: it.mode = srs_pkg::MODE_TIMEOUT;
        4: it.mode = srs_pkg::MODE_NONE;
        default: it.mode = srs_pkg::MODE_SEND;
      endcase
    end
    return it;
  endfunction

  task automatic queue_item(arq_item_t it);
    window_update_t u;
    while (item_queue.size() >= 16) @(negedge clk);
    u = window_step(plan_state, it);
    plan_state = u.win;
    item_queue = {item_queue, it};
  endtask

  task automatic apb_write(logic [1:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == WINDOW_SIZE_ADDR) plan_state.wsize = data[3:0];
  endtask

  // Wait until every item is taken and every result is back
  task automatic settle();
    while (item_queue.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_run(int n);
    repeat (n) queue_item(pick_item());
  endtask

  // Input driver
  always @(negedge clk) begin
    if (!s_axis_tvalid || s_fire) begin
      if (item_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drive_item = item_queue[0];
        item_queue.delete(0);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {drive_item.exp_seq, drive_item.ack_no, drive_item.payload};
        s_axis_tuser <= {drive_item.csum_ok, drive_item.mode};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: register writes, result check, prediction, watchdog
  always @(posedge clk) begin
    s_fire = s_axis_tvalid && s_axis_tready;
    m_fire = m_axis_tvalid && m_axis_tready;

    if (psel && penable && pwrite && pready && paddr == WINDOW_SIZE_ADDR)
      sender_state.wsize = pwdata[3:0];

    if (m_fire) begin
      got_res.status    = srs_pkg::status_t'(m_axis_tuser);
      got_res.seq       = m_axis_tdata[15:0];
      got_res.payload   = m_axis_tdata[47:16];
      got_res.start_tmr = m_axis_tdata[48];
      got_res.stop_tmr  = m_axis_tdata[49];
      got_res.full      = m_axis_tdata[50];
      got_res.released  = m_axis_tdata[54:51];
      if (due_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected result item: status %0d seq %h", got_res.status, got_res.seq);
      end else begin
        want_res = due_results[0];
        due_results.delete(0);
        if (got_res.status !== want_res.status || got_res.seq !== want_res.seq ||
            got_res.payload !== want_res.payload ||
            got_res.start_tmr !== want_res.start_tmr ||
            got_res.stop_tmr !== want_res.stop_tmr || got_res.full !== want_res.full ||
            got_res.released !== want_res.released) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("mismatch exp: st %0d seq %h pay %h start %b stop %b full %b rel %0d",
                     want_res.status, want_res.seq, want_res.payload, want_res.start_tmr,
                     want_res.stop_tmr, want_res.full, want_res.released);
            $display("         got: st %0d seq %h pay %h start %b stop %b full %b rel %0d",
                     got_res.status, got_res.seq, got_res.payload, got_res.start_tmr,
                     got_res.stop_tmr, got_res.full, got_res.released);
          end
        end
      end
    end

    if (s_fire) begin
      seen_item = mk_item(srs_pkg::mode_t'(s_axis_tuser[1:0]), s_axis_tdata[31:0],
                          s_axis_tdata[47:32], s_axis_tuser[2], s_axis_tdata[63:48]);
      upd = window_step(sender_state, seen_item);
      sender_state = upd.win;
      if (upd.has_res) due_results = {due_results, upd.res};
    end

    // watchdog on handshake activity
    if (s_fire || m_fire || (psel && penable && pwrite))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    sender_state = window_at_reset();
    plan_state = window_at_reset();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed opening, window of four from reset
    queue_item(mk_item(srs_pkg::MODE_ACK, 32'h0, 16'h0005, 1'b1, 16'h0));  // empty window
    queue_item(mk_item(srs_pkg::MODE_ACK, 32'h0, 16'hFFFF, 1'b0, 16'hFFFF)); // bad checksum
    queue_item(mk_item(srs_pkg::MODE_TIMEOUT, 32'h0, 16'h0, 1'b1, 16'h0000)); // no resend
    queue_item(mk_item(srs_pkg::MODE_NONE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'hFFFF));
    queue_item(mk_item(srs_pkg::MODE_SEND, 32'h0000_0000, 16'h0, 1'b0, 16'h0));
    queue_item(mk_item(srs_pkg::MODE_SEND, 32'hFFFF_FFFF, 16'h0, 1'b0, 16'h0));
    queue_item(mk_item(srs_pkg::MODE_SEND, 32'hA5A5_A5A5, 16'h0, 1'b0, 16'h0));
    queue_item(mk_item(srs_pkg::MODE_SEND, 32'h5A5A_5A5A, 16'h0, 1'b0, 16'h0)); // now full
    queue_item(mk_item(srs_pkg::MODE_SEND, 32'h1234_5678, 16'h0, 1'b0, 16'h0)); // refused
    queue_item(mk_item(srs_pkg::MODE_TIMEOUT, 32'h0, 16'h0, 1'b1, 16'd2));      // resend
    queue_item(mk_item(srs_pkg::MODE_TIMEOUT, 32'h0, 16'h0, 1'b1, 16'hFFFF));
    queue_item(mk_item(srs_pkg::MODE_ACK, 32'h0, 16'd2, 1'b1, 16'h0));    // not at head
    queue_item(mk_item(srs_pkg::MODE_ACK, 32'h0, 16'd3, 1'b0, 16'h0));
    queue_item(mk_item(srs_pkg::MODE_ACK, 32'h0, 16'hFFFF, 1'b1, 16'h0)); // older than head
    queue_item(mk_item(srs_pkg::MODE_ACK, 32'h0, 16'h0000, 1'b1, 16'h0));
    queue_item(mk_item(srs_pkg::MODE_ACK, 32'h0, 16'd100, 1'b1, 16'h0));  // not in window
    queue_item(mk_item(srs_pkg::MODE_TIMEOUT, 32'h0, 16'h0, 1'b1, 16'd2)); // already acked
    queue_item(mk_item(srs_pkg::MODE_ACK, 32'h0, 16'd1, 1'b1, 16'h0));    // slides two
    queue_item(mk_item(srs_pkg::MODE_ACK, 32'h0, 16'd4, 1'b1, 16'h0));
    queue_item(mk_item(srs_pkg::MODE_SEND, 32'hDEAD_BEEF, 16'h0, 1'b0, 16'h0));
    queue_item(mk_item(srs_pkg::MODE_ACK, 32'h0, 16'd3, 1'b1, 16'h0));
    queue_item(mk_item(srs_pkg::MODE_ACK, 32'h0, 16'd5, 1'b1, 16'h0));    // window empties
    queue_item(mk_item(srs_pkg::MODE_ACK, 32'h0, 16'd5, 1'b1, 16'h0));
    settle();

    // widest window, no idling
    apb_write(WINDOW_SIZE_ADDR, 32'd8);
    random_run(80);
    settle();

    // single-entry window, sender idling
    send_idle_pct = 62;
    apb_write(WINDOW_SIZE_ADDR, 32'd1);
    random_run(60);
    settle();

    // zero window refuses every send
    send_idle_pct = 0;
    apb_write(WINDOW_SIZE_ADDR, 32'd0);
    random_run(15);
    settle();

    // oversized value, receiver stalling and one long hold-off
    recv_stall_pct = 62;
    long_hold_req = 1'b1;
    apb_write(WINDOW_SIZE_ADDR, 32'd15);
    random_run(80);
    settle();

    // mid window, both sides idling
    send_idle_pct = 35;
    recv_stall_pct = 35;
    apb_write(WINDOW_SIZE_ADDR, 32'd5);
    random_run(80);
    settle();

    // widest window again, no idling
    send_idle_pct = 0;
    recv_stall_pct = 0;
    apb_write(WINDOW_SIZE_ADDR, 32'd8);
    random_run(60);
    settle();

    if (err_count == 0 && due_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
src/srs_pkg.sv
src/srs_ctrl.sv
src/srs_dp.sv
src/selective_repeat_sender_core.sv
src/srs_checker.sv
tb/tb_top.sv
